// File: src/stft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stft_pkg
// shared types and constants of the sparse triplet fast transpose unit
// ----------------------------------------------------------------------------
package stft_pkg;

	// payload field widths
	localparam int unsigned ROW_W      = 16;
	localparam int unsigned COL_W      = 8;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned TERM_W     = 7;
	localparam int unsigned NUM_COLS_W = 9;

	// capacity defaults and fixed column limit
	localparam int unsigned MAX_ENTRIES_DEF = 64;
	localparam int unsigned MAX_COLS        = 256;
	localparam int unsigned MAX_COLS_W      = 13;

	// register port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_NUM_COLS = 3'd0;
	localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 9'd256;

	// one stored triplet, as received
	typedef struct packed {
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          col;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic ins_en;
		logic pop_en;
	} cell_ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

// File: src/stft_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stft_cell
// one slot of the sorted chain: holds an entry, takes the new one, shifts
// ----------------------------------------------------------------------------
module stft_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stft_pkg::cell_ctl_t  ctl,
	input  stft_pkg::entry_t     new_entry,
	input  wire                  left_gt,
	input  wire                  left_occ,
	input  stft_pkg::entry_t     left_data,
	input  wire                  right_occ,
	input  stft_pkg::entry_t     right_data,
	output logic                 gt,
	output logic                 occ,
	output stft_pkg::entry_t     data
);

	logic             occ_q;
	stft_pkg::entry_t data_q;

	// an empty slot counts as holding a larger column; equal columns stay ahead
	assign gt   = !occ_q || (data_q.col > new_entry.col);
	assign occ  = occ_q;
	assign data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.pop_en) begin
			occ_q <= right_occ;
		end else if (ctl.ins_en && gt) begin
			occ_q <= left_gt ? left_occ : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop_en) begin
			data_q <= right_data;
		end else if (ctl.ins_en && gt) begin
			data_q <= left_gt ? left_data : new_entry;
		end
	end

endmodule
`default_nettype wire

// File: src/stft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stft_ctrl
// load / drain sequencer, kept-entry count and drop flag
// ----------------------------------------------------------------------------
module stft_ctrl #(
	parameter int unsigned MAX_ENTRIES = stft_pkg::MAX_ENTRIES_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire                                 last_entry,
	input  wire [stft_pkg::COL_W-1:0]           entry_col,
	input  wire [stft_pkg::NUM_COLS_W-1:0]      num_cols,
	input  wire                                 out_ready,
	input  wire                                 next_occ,
	output logic                                in_ready,
	output logic                                out_valid,
	output logic                                last_result,
	output logic [stft_pkg::TERM_W-1:0]         term_count,
	output logic                                dropped,
	output stft_pkg::cell_ctl_t                 ctl
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	stft_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	logic             in_fire;
	logic             col_ok;
	logic             keep;
	logic             clr;

	assign in_fire = in_valid && in_ready;
	assign col_ok  = ({1'b0, entry_col} < num_cols) &&
		(stft_pkg::MAX_COLS_W'(entry_col) < stft_pkg::MAX_COLS_W'(stft_pkg::MAX_COLS));
	assign keep    = in_fire && col_ok && (count_q < CNT_W'(MAX_ENTRIES));

	assign last_result = !next_occ;
	assign term_count  = stft_pkg::TERM_W'(count_q);
	assign dropped     = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stft_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		clr        = 1'b0;
		ctl.ins_en = 1'b0;
		ctl.pop_en = 1'b0;
		unique case (state_q)
			stft_pkg::ST_LOAD: begin
				in_ready   = 1'b1;
				ctl.ins_en = keep;
				if (in_fire && last_entry) begin
					if (keep || (count_q != '0)) begin
						state_d = stft_pkg::ST_DRAIN;
					end else begin
						clr = 1'b1;
					end
				end
			end
			stft_pkg::ST_DRAIN: begin
				out_valid  = 1'b1;
				ctl.pop_en = out_ready;
				if (out_ready && last_result) begin
					state_d = stft_pkg::ST_LOAD;
					clr     = 1'b1;
				end
			end
			default: begin
				state_d = stft_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (clr) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (keep) begin
				count_q <= count_q + 1'b1;
			end
			if (in_fire && !keep) begin
				drop_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/sparse_triplet_fast_transpose_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triplet_fast_transpose_unit
// transposes a sparse matrix given as (row, column, value) triplets by a
// stable sort on the original column, held in a chain of insertion cells
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  ------------------------------------------------------------------------
//  entry     in         in_valid/in_ready   entry_row entry_col entry_value
//                                           last_entry
//  result    out        out_valid/out_ready out_row out_col out_value
//                                           term_count dropped last_result
//  config    in         apb psel/penable    num_cols at byte address 0
//
//  entries load one per cycle; each kept entry is inserted into its sorted
//  place in the cell chain in the cycle it is accepted
//  after the transaction marked last_entry the chain drains from its head, one
//  result per cycle while out_ready is high; each accepted result shifts the
//  whole chain by one cell toward its head
//  in_ready is low while the chain drains; a stall on out_ready holds the head
//  reset clears the cell occupancy, count, drop flag and sets num_cols to 256
//
module sparse_triplet_fast_transpose_unit #(
	parameter int unsigned MAX_ENTRIES = stft_pkg::MAX_ENTRIES_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// apb register port
	input  wire                                    psel,
	input  wire                                    penable,
	input  wire                                    pwrite,
	input  wire [stft_pkg::PADDR_W-1:0]            paddr,
	input  wire [stft_pkg::PDATA_W-1:0]            pwdata,
	output logic [stft_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready,
	// entry channel
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire [stft_pkg::ROW_W-1:0]              entry_row,
	input  wire [stft_pkg::COL_W-1:0]              entry_col,
	input  wire signed [stft_pkg::VALUE_W-1:0]     entry_value,
	input  wire                                    last_entry,
	// result channel
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [stft_pkg::COL_W-1:0]             out_row,
	output logic [stft_pkg::ROW_W-1:0]             out_col,
	output logic signed [stft_pkg::VALUE_W-1:0]    out_value,
	output logic [stft_pkg::TERM_W-1:0]            term_count,
	output logic                                   dropped,
	output logic                                   last_result
);

	logic [stft_pkg::NUM_COLS_W-1:0] num_cols_q;
	logic                            cfg_wr;
	stft_pkg::cell_ctl_t             ctl;
	stft_pkg::entry_t                new_entry;
	stft_pkg::entry_t                cell_data [MAX_ENTRIES];
	logic                            cell_occ  [MAX_ENTRIES];
	logic                            cell_gt   [MAX_ENTRIES];
	logic                            next_occ;

	// register port: zero wait states, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == stft_pkg::ADDR_NUM_COLS) ?
		stft_pkg::PDATA_W'(num_cols_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= stft_pkg::NUM_COLS_RESET;
		end else if (cfg_wr && (paddr == stft_pkg::ADDR_NUM_COLS)) begin
			num_cols_q <= pwdata[stft_pkg::NUM_COLS_W-1:0];
		end
	end

	// incoming transaction broadcast to all cells
	assign new_entry.row   = entry_row;
	assign new_entry.col   = entry_col;
	assign new_entry.value = entry_value;

	// chain of cells: cell 0 is the head, kept sorted by column, ties in order
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic             l_gt;
		logic             l_occ;
		stft_pkg::entry_t l_data;
		logic             r_occ;
		stft_pkg::entry_t r_data;

		if (i == 0) begin : g_head
			assign l_gt   = 1'b0;
			assign l_occ  = 1'b0;
			assign l_data = new_entry;
		end else begin : g_body
			assign l_gt   = cell_gt[i-1];
			assign l_occ  = cell_occ[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign r_occ  = 1'b0;
			assign r_data = new_entry;
		end else begin : g_inner
			assign r_occ  = cell_occ[i+1];
			assign r_data = cell_data[i+1];
		end

		stft_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.left_gt    (l_gt),
			.left_occ   (l_occ),
			.left_data  (l_data),
			.right_occ  (r_occ),
			.right_data (r_data),
			.gt         (cell_gt[i]),
			.occ        (cell_occ[i]),
			.data       (cell_data[i])
		);
	end

	// the head's neighbor tells whether the head is the final result
	if (MAX_ENTRIES > 1) begin : g_next
		assign next_occ = cell_occ[1];
	end else begin : g_single
		assign next_occ = 1'b0;
	end

	stft_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_entry  (last_entry),
		.entry_col   (entry_col),
		.num_cols    (num_cols_q),
		.out_ready   (out_ready),
		.next_occ    (next_occ),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.last_result (last_result),
		.term_count  (term_count),
		.dropped     (dropped),
		.ctl         (ctl)
	);

	// head cell drives the result, row and column swapped
	assign out_row   = cell_data[0].col;
	assign out_col   = cell_data[0].row;
	assign out_value = cell_data[0].value;

	// loading and draining never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("entry and result channels open together");

	// a shown result always comes from an occupied head
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_occ[0])
		else $error("result shown from an empty head cell");

	// the final result returns the block to loading with an empty chain
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> (in_ready && !cell_occ[0]))
		else $error("chain not empty after the final result");

	// occupancy is a prefix of the chain
	if (MAX_ENTRIES > 1) begin : g_prefix_chk
		a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			cell_occ[1] |-> cell_occ[0])
			else $error("gap in the cell chain");
	end

endmodule
`default_nettype wire
